FILE: hw/rtl/dvh_pkg.sv
// Shared types and constants for the distinct value histogram unit.
package dvh_pkg;

  localparam int VALUE_W         = 32;
  localparam int BIN_COUNT_W     = 16;
  localparam int TABLE_DEPTH_DEF = 32;
  localparam int COUNT_BITS_DEF  = 16;
  localparam int QUEUE_DEPTH     = 2;

  typedef struct packed {
    logic signed [VALUE_W-1:0] sample_value;
    logic                      final_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0]   bin_value;
    logic        [BIN_COUNT_W-1:0] bin_count;
    logic                        final_bin;
    logic                        table_overflow;
  } out_item_t;

  // Head of the item queue as seen by the back end.
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } queue_head_t;

endpackage

FILE: hw/rtl/dvh_front.sv
// Front end: accepts items and buffers them in a short queue for the back end.
module dvh_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  dvh_pkg::in_item_t   in_item,
  output dvh_pkg::queue_head_t head,
  input  logic                pop
);
  import dvh_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  in_item_t           slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   fill_r, fill_nxt;
  logic               push;
  logic               do_pop;

  assign busy   = (fill_r == CNT_W'(QUEUE_DEPTH));
  assign push   = start && !busy;
  assign do_pop = pop && (fill_r != '0);

  assign head.valid = (fill_r != '0);
  assign head.item  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !do_pop) begin
      fill_nxt = fill_r + CNT_W'(1);
    end else if (do_pop && !push) begin
      fill_nxt = fill_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= in_item;
    end
  end

endmodule

FILE: hw/rtl/dvh_bins.sv
// Back end: bin cells with parallel match, and the drain that shifts bins out.
module dvh_bins #(
  parameter int TABLE_DEPTH = dvh_pkg::TABLE_DEPTH_DEF,
  parameter int COUNT_BITS  = dvh_pkg::COUNT_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dvh_pkg::queue_head_t head,
  output logic                 pop,
  output logic                 out_valid,
  output dvh_pkg::out_item_t   out_item
);
  import dvh_pkg::*;

  localparam int UW = $clog2(TABLE_DEPTH + 1);
  localparam logic ST_ABSORB = 1'b0;
  localparam logic ST_DRAIN  = 1'b1;

  logic signed [VALUE_W-1:0] val_r [TABLE_DEPTH];
  logic [COUNT_BITS-1:0]     cnt_r [TABLE_DEPTH];

  logic            st_r, st_nxt;
  logic [UW-1:0]   used_r, used_nxt;
  logic [UW-1:0]   rem_r, rem_nxt;
  logic            ovf_r, ovf_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_item_r, out_item_nxt;

  logic [TABLE_DEPTH-1:0] hit_vec;
  logic                   hit;
  logic                   room;
  logic                   absorb;
  logic [31:0]            head_cnt_ext;

  assign pop    = (st_r == ST_ABSORB);
  assign absorb = pop && head.valid;
  assign hit    = |hit_vec;
  assign room   = (used_r != UW'(TABLE_DEPTH));

  assign head_cnt_ext = 32'(cnt_r[0]);

  genvar gi;
  generate
    for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
      assign hit_vec[gi] = (UW'(gi) < used_r) &&
                           (val_r[gi] == head.item.sample_value);

      always_ff @(posedge clk) begin
        if (st_r == ST_DRAIN) begin
          // shift toward cell 0 so the next bin is ready for output
          if (gi < TABLE_DEPTH - 1) begin
            val_r[gi] <= val_r[(gi < TABLE_DEPTH - 1) ? gi + 1 : gi];
            cnt_r[gi] <= cnt_r[(gi < TABLE_DEPTH - 1) ? gi + 1 : gi];
          end
        end else if (absorb) begin
          if (hit_vec[gi]) begin
            if (cnt_r[gi] != {COUNT_BITS{1'b1}}) begin
              cnt_r[gi] <= cnt_r[gi] + COUNT_BITS'(1);
            end
          end else if (!hit && used_r == UW'(gi)) begin
            val_r[gi] <= head.item.sample_value;
            cnt_r[gi] <= COUNT_BITS'(1);
          end
        end
      end
    end
  endgenerate

  always_comb begin
    st_nxt        = st_r;
    used_nxt      = used_r;
    rem_nxt       = rem_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    case (st_r)
      ST_ABSORB: begin
        if (absorb) begin
          if (!hit) begin
            if (room) begin
              used_nxt = used_r + UW'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
          end
          if (head.item.final_sample) begin
            st_nxt  = ST_DRAIN;
            rem_nxt = used_nxt;
          end
        end
      end
      ST_DRAIN: begin
        out_valid_nxt               = 1'b1;
        out_item_nxt.bin_value      = val_r[0];
        out_item_nxt.bin_count      = head_cnt_ext[BIN_COUNT_W-1:0];
        out_item_nxt.final_bin      = (rem_r == UW'(1));
        out_item_nxt.table_overflow = ovf_r;
        rem_nxt                     = rem_r - UW'(1);
        if (rem_r == UW'(1)) begin
          // clear the table for the next set
          st_nxt   = ST_ABSORB;
          used_nxt = '0;
          ovf_nxt  = 1'b0;
        end
      end
      default: begin
        st_nxt = ST_ABSORB;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_ABSORB;
      used_r      <= '0;
      rem_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      used_r      <= used_nxt;
      rem_r       <= rem_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

FILE: hw/rtl/distinct_value_histogram_unit.sv
// Distinct value histogram unit: counts distinct values of a set and emits one bin per value.
// Items enter through a two-entry queue at up to one per cycle while busy is low; each is
// matched against all used bins in parallel, so a set of values streams in without pause. The
// item that carries final_sample is counted, then the bins are shifted out in order of first
// appearance, one result per cycle on out_valid/out_item, each through the registered output
// after the drain state is entered. While a drain runs the bin table takes no items; busy rises
// once the queue fills behind it. Results cannot be held off and must be taken in the cycle they
// appear. Counts saturate at 2^COUNT_BITS - 1; a new value that finds all TABLE_DEPTH bins used
// is dropped and sets table_overflow on every result of that set.
module distinct_value_histogram_unit #(
  parameter int TABLE_DEPTH = dvh_pkg::TABLE_DEPTH_DEF,
  parameter int COUNT_BITS  = dvh_pkg::COUNT_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  dvh_pkg::in_item_t  in_item,
  output logic               out_valid,
  output dvh_pkg::out_item_t out_item
);
  import dvh_pkg::*;

  queue_head_t head;
  logic        pop;

  dvh_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_item (in_item),
    .head    (head),
    .pop     (pop)
  );

  dvh_bins #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .COUNT_BITS  (COUNT_BITS)
  ) u_bins (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

FILE: hw/rtl/dvh_checker.sv
// Port-level checks for the distinct value histogram unit, bound to the top level.
module dvh_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input dvh_pkg::out_item_t out_item
);
  import dvh_pkg::*;

  // a drain runs without gaps until its last bin
  a_drain_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.final_bin |=> out_valid)
    else $error("drain broke off before the last bin");

  // overflow flag is the same on every bin of a set
  a_overflow_steady: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.final_bin |=> $stable(out_item.table_overflow))
    else $error("overflow flag changed within a set");

  // reset leaves no result pending and the queue empty
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !busy)
    else $error("result or busy seen right after reset");

  // the bin table returns to counting after the last bin, so the result strobe drops after it
  a_gap_after_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.final_bin |=> !out_valid)
    else $error("result strobe stayed high after the last bin of a set");

  // the queue only fills up through an accepted item
  a_busy_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start && !busy))
    else $error("busy rose without an accepted item");

endmodule

bind distinct_value_histogram_unit dvh_checker u_dvh_checker (.*);
